// ----- hw/rtl/fbpa_pkg.sv -----
package fbpa_pkg;

  // Pool geometry; block indices are 8 bits, so the pool holds at most 256 blocks.
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned PADDR_W    = 2;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [CNT_W-1:0] MaxBlocksCnt = CNT_W'(MAX_BLOCKS);

  // Byte address of the block count register.
  localparam logic [PADDR_W-1:0] AddrBlockCount = '0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] min_free;
    logic             all_recycled;
  } rsp_t;

  // Classified request as it sits in the queue between front and back.
  typedef struct packed {
    logic             is_put;
    logic             in_range;
    logic [IDX_W-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_t;

endpackage

// ----- hw/rtl/fbpa_stream_if.sv -----
interface fbpa_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/fbpa_front.sv -----
module fbpa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fbpa_pkg::CNT_W-1:0]    bc_i,
  fbpa_stream_if.sink                   req_i,
  output fbpa_pkg::queue_t              q_o,
  input  logic                          q_pop_i
);
  import fbpa_pkg::*;

  entry_t     fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  entry_t     entry_in;

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;

  // Range check is done here so the back end only sees a ready-made flag.
  assign entry_in.is_put   = (req_i.data.op == OP_PUT);
  assign entry_in.in_range = ({1'b0, req_i.data.block_index} < bc_i);
  assign entry_in.idx      = req_i.data.block_index;

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.entry = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry_in;
    end
  end

endmodule

// ----- hw/rtl/fbpa_back.sv -----
module fbpa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fbpa_pkg::CNT_W-1:0]    bc_i,
  input  logic                          init_i,
  input  fbpa_pkg::queue_t              q_i,
  output logic                          q_pop_o,
  fbpa_stream_if.source                 rsp_o
);
  import fbpa_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StLink = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] rec_len_q, rec_len_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] low_q, low_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] link_rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;

  logic             out_free;
  logic [CNT_W-1:0] free_dec;
  logic [CNT_W-1:0] low_dec;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  assign free_dec = free_q - CNT_W'(1);
  assign low_dec  = (free_dec < low_q) ? free_dec : low_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    rec_len_d   = rec_len_q;
    fresh_d     = fresh_q;
    free_d      = free_q;
    low_d       = low_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = q_i.entry.idx;

    if (init_i) begin
      state_d   = StIdle;
      head_d    = '0;
      rec_len_d = '0;
      fresh_d   = '0;
      free_d    = bc_i;
      low_d     = bc_i;
    end else begin
      case (state_q)
        StIdle: begin
          if (q_i.valid && out_free) begin
            q_pop_o       = 1'b1;
            out_d.status  = ST_OK;
            out_d.granted_index = '0;
            out_d.free_count    = free_q;
            out_d.min_free      = low_q;
            out_d.all_recycled  = (free_q >= bc_i);
            if (!q_i.entry.is_put) begin
              if (free_q != '0 && rec_len_q != '0) begin
                // Head link comes back from the memory next cycle.
                state_d = StLink;
              end else if (free_q != '0 && fresh_q < bc_i) begin
                fresh_d             = fresh_q + CNT_W'(1);
                free_d              = free_dec;
                low_d               = low_dec;
                out_d.granted_index = fresh_q[IDX_W-1:0];
                out_d.free_count    = free_dec;
                out_d.min_free      = low_dec;
                out_d.all_recycled  = (free_dec >= bc_i);
                out_valid_d         = 1'b1;
              end else begin
                out_d.status = ST_EMPTY;
                out_valid_d  = 1'b1;
              end
            end else begin
              if (!q_i.entry.in_range) begin
                out_d.status = ST_RANGE;
              end else if (free_q >= bc_i) begin
                out_d.status = ST_FULL;
              end else begin
                mem_we             = 1'b1;
                head_d             = q_i.entry.idx;
                rec_len_d          = rec_len_q + CNT_W'(1);
                free_d             = free_q + CNT_W'(1);
                out_d.free_count   = free_q + CNT_W'(1);
                out_d.all_recycled = ((free_q + CNT_W'(1)) >= bc_i);
              end
              out_valid_d = 1'b1;
            end
          end
        end
        StLink: begin
          // The output slot was free when this get left the queue.
          head_d              = link_rd_q;
          rec_len_d           = rec_len_q - CNT_W'(1);
          free_d              = free_dec;
          low_d               = low_dec;
          out_d.status        = ST_OK;
          out_d.granted_index = head_q;
          out_d.free_count    = free_dec;
          out_d.min_free      = low_dec;
          out_d.all_recycled  = (free_dec >= bc_i);
          out_valid_d         = 1'b1;
          state_d             = StIdle;
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      rec_len_q   <= '0;
      fresh_q     <= '0;
      free_q      <= MaxBlocksCnt;
      low_q       <= MaxBlocksCnt;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      rec_len_q   <= rec_len_d;
      fresh_q     <= fresh_d;
      free_q      <= free_d;
      low_q       <= low_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= head_q;
    end
    link_rd_q <= link_mem[head_q];
  end

endmodule

// ----- hw/rtl/fixed_block_pool_allocator_top.sv -----
// Channel   Dir  Beat payload                                        Handshake
// req_i     in   op, block_index                                     valid/ready
// rsp_o     out  status, granted_index, free_count, min_free,        valid/ready
//                all_recycled
// apb       in   block_count at byte address 0                       psel/penable
//
// A put, a get served from the fresh counter and every rejected request finish in
// the back end's idle state; a get served from the recycled list also passes the
// link state, as the head link is read from the link memory by a registered port.
// Reset gives a pool of 256 blocks; writing block_count re-initializes the pool.
// A two-beat queue sits between request decode and execution, and one output
// register holds the result, so the request side can take two more beats while
// rsp_o stalls.
module fixed_block_pool_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0]    paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0]    pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  fbpa_stream_if.sink                     req_i,
  fbpa_stream_if.source                   rsp_o
);
  import fbpa_pkg::*;

  logic [CNT_W-1:0] bc_q, bc_d;
  logic             cfg_wr;
  logic             init;
  queue_t           queue;
  logic             q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign init   = cfg_wr && (paddr == AddrBlockCount);
  assign bc_d   = (pwdata[CNT_W-1:0] > MaxBlocksCnt) ? MaxBlocksCnt : pwdata[CNT_W-1:0];
  assign prdata = (paddr == AddrBlockCount) ? {{(PDATA_W-CNT_W){1'b0}}, bc_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= MaxBlocksCnt;
    end else if (init) begin
      bc_q <= bc_d;
    end
  end

  fbpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bc_i    (bc_q),
    .req_i   (req_i),
    .q_o     (queue),
    .q_pop_i (q_pop)
  );

  fbpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bc_i    (init ? bc_d : bc_q),
    .init_i  (init),
    .q_i     (queue),
    .q_pop_o (q_pop),
    .rsp_o   (rsp_o)
  );

endmodule
